FILE: sv/ctlb_pkg.sv
// ctlb_pkg: shared types and constants for the cursor text line buffer.
// No dependencies; imported by the interface, the cell and the top level.
package ctlb_pkg;

	localparam int POS_W  = 6;
	localparam int CHAR_W = 8;

	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;

	typedef enum logic [2:0] {
		FUNC_INSERT  = 3'd0,
		FUNC_DELETE  = 3'd1,
		FUNC_LEFT    = 3'd2,
		FUNC_RIGHT   = 3'd3,
		FUNC_HOME    = 3'd4,
		FUNC_DISPLAY = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		KIND_DONE     = 2'd0,
		KIND_NOEFFECT = 2'd1,
		KIND_FULL     = 2'd2,
		KIND_CHAR     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_DELETE,
		CELL_ROTATE
	} cell_op_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_DISP
	} state_t;

	typedef struct packed {
		logic [2:0]        func;
		logic [CHAR_W-1:0] char_in;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [CHAR_W-1:0] char_out;
		logic              last;
	} rsp_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		cell_op_t          op;
		logic [POS_W-1:0]  cursor;
		logic [POS_W-1:0]  length;
		logic [CHAR_W-1:0] char_in;
	} cell_ctrl_t;

endpackage

FILE: sv/ctlb_chan_if.sv
// ctlb_chan_if: valid/ready channel carrying one request payload.
// Depends on ctlb_pkg for the default payload type.
interface ctlb_chan_if
	import ctlb_pkg::*;
#(
	parameter type payload_t = cmd_t
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/ctlb_cell.sv
// ctlb_cell: one character slot of the text chain.
// Depends on ctlb_pkg; loads from its left or right neighbour, the first cell or char_in.
module ctlb_cell
	import ctlb_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	input  logic [CHAR_W-1:0] left_data,
	input  logic [CHAR_W-1:0] right_data,
	input  logic [CHAR_W-1:0] first_data,
	output logic [CHAR_W-1:0] data
);
	localparam logic [POS_W:0] IDX_P = (POS_W+1)'(IDX);

	logic [POS_W:0] idx_next;
	logic [POS_W:0] cur_x;
	logic [POS_W:0] len_x;
	logic [CHAR_W-1:0] data_q;

	assign idx_next = IDX_P + 1'b1;
	assign cur_x    = {1'b0, ctrl.cursor};
	assign len_x    = {1'b0, ctrl.length};
	assign data     = data_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_INSERT: begin
				if (IDX_P == cur_x) begin
					data_q <= ctrl.char_in;
				end else if (IDX_P > cur_x) begin
					data_q <= left_data;
				end
			end
			CELL_DELETE: begin
				if (IDX_P >= cur_x && idx_next < len_x) begin
					data_q <= right_data;
				end
			end
			CELL_ROTATE: begin
				if (idx_next < len_x) begin
					data_q <= right_data;
				end else if (idx_next == len_x) begin
					data_q <= first_data;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end
endmodule

FILE: sv/cursor_text_line_buffer_top.sv
// channel | dir | payload                      | handshake
// cmd     | in  | func[2:0], char_in[7:0]      | valid/ready
// rsp     | out | kind[1:0], char_out[7:0], last | valid/ready
//
// Edit commands shift the affected characters of the cell chain in parallel.
// Display emits the text's characters and then a newline; the chain rotates by
// one per emitted character, so cell 0 always presents the next byte.
// Reset clears length, cursor and control; cell contents are undefined.
// A held response stalls the chain; a new command is taken while idle and the
// output register is free or draining.
module cursor_text_line_buffer_top
	import ctlb_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	ctlb_chan_if.sink   cmd,
	ctlb_chan_if.source rsp
);
	localparam logic [POS_W-1:0] CAP_P = POS_W'(CAPACITY);

	state_t           state_q, state_d;
	logic [POS_W-1:0] len_q, len_d;
	logic [POS_W-1:0] cur_q, cur_d;
	logic [POS_W-1:0] cnt_q, cnt_d;
	logic             ov_q, ov_d;
	rsp_t             rsp_q, rsp_d;
	cell_ctrl_t       ctrl;
	logic             out_free;
	logic             accept;
	logic [CHAR_W-1:0] cell_data [CAPACITY];

	assign out_free    = !ov_q || rsp.ready;
	assign cmd.ready   = (state_q == ST_IDLE) && out_free;
	assign accept      = cmd.valid && cmd.ready;
	assign rsp.valid   = ov_q;
	assign rsp.payload = rsp_q;

	always_comb begin
		state_d      = state_q;
		len_d        = len_q;
		cur_d        = cur_q;
		cnt_d        = cnt_q;
		ov_d         = ov_q && !rsp.ready;
		rsp_d        = rsp_q;
		ctrl.op      = CELL_HOLD;
		ctrl.cursor  = cur_q;
		ctrl.length  = len_q;
		ctrl.char_in = cmd.payload.char_in;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ov_d           = 1'b1;
					rsp_d.kind     = KIND_NOEFFECT;
					rsp_d.char_out = '0;
					rsp_d.last     = 1'b1;
					case (cmd.payload.func)
						FUNC_INSERT: begin
							if (len_q >= CAP_P || cur_q > len_q) begin
								rsp_d.kind = KIND_FULL;
							end else begin
								ctrl.op    = CELL_INSERT;
								len_d      = len_q + 1'b1;
								cur_d      = cur_q + 1'b1;
								rsp_d.kind = KIND_DONE;
							end
						end
						FUNC_DELETE: begin
							if (cur_q != '0 && cur_q < len_q) begin
								ctrl.op    = CELL_DELETE;
								len_d      = len_q - 1'b1;
								rsp_d.kind = KIND_DONE;
							end
						end
						FUNC_LEFT: begin
							if (cur_q != '0) begin
								cur_d      = cur_q - 1'b1;
								rsp_d.kind = KIND_DONE;
							end
						end
						FUNC_RIGHT: begin
							if (cur_q != '0 && cur_q < len_q) begin
								cur_d      = cur_q + 1'b1;
								rsp_d.kind = KIND_DONE;
							end
						end
						FUNC_HOME: begin
							cur_d      = '0;
							rsp_d.kind = KIND_DONE;
						end
						FUNC_DISPLAY: begin
							ov_d    = 1'b0;
							cnt_d   = '0;
							state_d = ST_DISP;
						end
						default: begin
							rsp_d.kind = KIND_NOEFFECT;
						end
					endcase
				end
			end
			ST_DISP: begin
				if (out_free) begin
					ov_d       = 1'b1;
					rsp_d.kind = KIND_CHAR;
					if (cnt_q < len_q) begin
						rsp_d.char_out = cell_data[0];
						rsp_d.last     = 1'b0;
						cnt_d          = cnt_q + 1'b1;
						ctrl.op        = CELL_ROTATE;
					end else begin
						rsp_d.char_out = NEWLINE_CHAR;
						rsp_d.last     = 1'b1;
						state_d        = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= '0;
			cur_q   <= '0;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			cur_q   <= cur_d;
			cnt_q   <= cnt_d;
			ov_q    <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [CHAR_W-1:0] left_w;
		logic [CHAR_W-1:0] right_w;

		if (g == 0) begin : g_first
			assign left_w = cell_data[g];
		end else begin : g_mid_l
			assign left_w = cell_data[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_w = cell_data[g];
		end else begin : g_mid_r
			assign right_w = cell_data[g+1];
		end

		ctlb_cell #(
			.IDX(g)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.left_data (left_w),
			.right_data(right_w),
			.first_data(cell_data[0]),
			.data      (cell_data[g])
		);
	end
endmodule
